// File: hw/rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and types for the listener gain slew block: register
// indexes, rate constants of the smoothing step and the sequencer controls.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE             = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SETTING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNFOCUSED_FACTOR = 2'd2;

    // Smoothing rate: 0.006 per millisecond held with 24 fraction bits
    localparam int RATE_FRAC = 24;
    localparam int K_W       = RATE_FRAC + 1;
    localparam int RATE_W    = 17;
    localparam logic [RATE_W-1:0] RATE_PER_MS = 17'd100663;
    localparam logic [K_W-1:0]    RATE_ONE    = K_W'(1) << RATE_FRAC;
    localparam logic [K_W-1:0]    RATE_HALF   = K_W'(1) << (RATE_FRAC - 1);

    // Elapsed time of a smoothing step is held in 16 bits; past the gap limit the gain jumps
    localparam int DT_W   = 16;
    localparam int TIME_W = 64;

    // One-hot step strobes from the sequencer to the datapath
    typedef struct packed {
        logic step_target;   // multiply clamped volume by unfocused factor
        logic step_rate;     // form target, multiply dt by rate
        logic step_move;     // clamp k, multiply magnitude by k
        logic step_finish;   // apply move, snap, update state and result
    } lgs_ctrl_t;

endpackage

// File: hw/rtl/lgs_mul.sv
// ----------------------------------------------------------------------------
// lgs_mul
// Shared unsigned multiplier with a registered product, reused by every
// multiply step of the smoothing sequence. The product holds between loads.
// ----------------------------------------------------------------------------
module lgs_mul #(
    parameter int A_W = 25,
    parameter int B_W = 25
) (
    input  logic               clk,
    input  logic               load,
    input  logic [A_W-1:0]     op_a,
    input  logic [B_W-1:0]     op_b,
    output logic [A_W+B_W-1:0] product
);

    logic [A_W+B_W-1:0] product_reg;

    // Register the product for the next step, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
        end
    end

    assign product = product_reg;

endmodule

// File: hw/rtl/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// lgs_ctrl
// Sequencer of the smoothing step: takes one word, walks it through the
// three uses of the shared multiplier and a finish step, and holds the
// finish step until the result register is free.
// ----------------------------------------------------------------------------
module lgs_ctrl
    import lgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    output lgs_ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TARGET = 3'd1;
    localparam logic [2:0] S_RATE   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Advance through the steps
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_TARGET;
                end
            end
            S_TARGET: state_next = S_RATE;
            S_RATE:   state_next = S_MOVE;
            S_MOVE:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode step strobes
    assign in_ready         = (state_reg == S_IDLE);
    assign ctrl.step_target = (state_reg == S_TARGET);
    assign ctrl.step_rate   = (state_reg == S_RATE);
    assign ctrl.step_move   = (state_reg == S_MOVE);
    assign ctrl.step_finish = (state_reg == S_FINISH) && out_free;

endmodule

// File: hw/rtl/listener_gain_slew.sv
// ----------------------------------------------------------------------------
// listener_gain_slew
// Smooths the listener gain toward a target once per tick: the target comes
// from mute, volume and the focus flag, the stored gain jumps or slews toward
// it by a factor that grows with elapsed milliseconds.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------
//   in       | in_valid / in_ready  | time_ms, window_active
//   out      | out_valid / out_ready| gain
//   cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// Each word goes from the accept in the idle state through three steps that
// each use the single shared multiplier (focus scaling, dt times rate,
// magnitude times k) and a finish step that applies the move and registers
// the result; the next word is taken only once the sequencer idles again.
// in_ready is high only while the sequencer idles. A stalled result holds
// the finish step, and the held product, until the output register is free.
// Reset clears the stored gain, the last time and the initialized flag;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module listener_gain_slew
    import lgs_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16,
    parameter int GAP_LIMIT_MS   = 1000
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [TIME_W-1:0]         time_ms,
    input  logic                      window_active,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [GAIN_FRAC_BITS:0]   gain,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GAIN_FRAC_BITS+1:0] cfg_data
);

    localparam int GW      = GAIN_FRAC_BITS + 1;
    localparam int VW      = GAIN_FRAC_BITS + 2;
    localparam int MUL_A_W = (GW > DT_W) ? GW : DT_W;
    localparam int MUL_B_W = (GW > K_W) ? GW : K_W;
    localparam int P_W     = MUL_A_W + MUL_B_W;
    localparam logic [GW-1:0] GAIN_ONE  = GW'(1) << GAIN_FRAC_BITS;
    localparam logic [GW-1:0] SNAP_DIST =
        GW'(((2 * (1 << GAIN_FRAC_BITS)) + 500) / 1000);
    localparam logic [TIME_W-1:0] GAP_LIMIT = TIME_W'(GAP_LIMIT_MS);

    // Configuration registers
    logic          mute_reg;
    logic [VW-1:0] volume_reg;
    logic [GW-1:0] factor_reg;

    // Working registers of one word
    logic [TIME_W-1:0] now_reg;
    logic              active_reg;
    logic [DT_W-1:0]   dt_reg;
    logic              jump_reg;
    logic [GW-1:0]     target_reg;
    logic              up_reg;

    // Block state and result
    logic [GW-1:0]     smoothed_reg;
    logic              valid_reg;
    logic [TIME_W-1:0] last_reg;
    logic [GW-1:0]     gain_out_reg;
    logic              out_valid_reg;

    lgs_ctrl_t        ctrl;
    logic             out_free;
    logic             mul_load;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [P_W-1:0]     prod;

    logic [GW-1:0]     vol_clamped;
    logic [TIME_W-1:0] dt_full;
    logic [P_W:0]      scaled_round;
    logic [P_W:0]      scaled;
    logic [GW-1:0]     target_calc;
    logic [K_W-1:0]    k_val;
    logic [GW-1:0]     mag;
    logic [P_W:0]      move_round;
    logic [GW-1:0]     move;
    logic [GW-1:0]     stepped;
    logic [GW-1:0]     snap_diff;
    logic [GW-1:0]     gain_new;

    assign out_free = !out_valid_reg || out_ready;
    assign mul_load = ctrl.step_target || ctrl.step_rate || ctrl.step_move;

    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    lgs_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk     (clk),
        .load    (mul_load),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    // Take register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_reg   <= 1'b0;
            volume_reg <= VW'(GAIN_ONE);
            factor_reg <= GAIN_ONE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MUTE:             mute_reg   <= cfg_data[0];
                CFG_VOLUME_SETTING:   volume_reg <= cfg_data;
                CFG_UNFOCUSED_FACTOR: factor_reg <= cfg_data[GW-1:0];
                default:              ;
            endcase
        end
    end

    // Clamp the volume to 0..1.0
    always_comb
    begin
        if (volume_reg[VW-1])
        begin
            vol_clamped = '0;
        end
        else if (volume_reg > VW'(GAIN_ONE))
        begin
            vol_clamped = GAIN_ONE;
        end
        else
        begin
            vol_clamped = volume_reg[GW-1:0];
        end
    end

    // Elapsed time against the previous tick
    assign dt_full = now_reg - last_reg;

    // Round the focus scaling and clamp again; an active window takes the clamped volume unscaled, mute forces zero
    assign scaled_round = {1'b0, prod} + (P_W+1)'(GAIN_ONE >> 1);
    assign scaled       = scaled_round >> GAIN_FRAC_BITS;
    always_comb
    begin
        if (mute_reg)
        begin
            target_calc = '0;
        end
        else if (active_reg)
        begin
            target_calc = vol_clamped;
        end
        else if (scaled > (P_W+1)'(GAIN_ONE))
        begin
            target_calc = GAIN_ONE;
        end
        else
        begin
            target_calc = scaled[GW-1:0];
        end
    end

    // Limit k to 1.0 and form the distance to the target
    assign k_val = (prod > P_W'(RATE_ONE)) ? RATE_ONE : prod[K_W-1:0];
    assign mag   = up_reg ? (target_reg - smoothed_reg) : (smoothed_reg - target_reg);

    // Select multiplier operands for each step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (ctrl.step_target)
        begin
            mul_a = MUL_A_W'(vol_clamped);
            mul_b = MUL_B_W'(factor_reg);
        end
        else if (ctrl.step_rate)
        begin
            mul_a = MUL_A_W'(dt_reg);
            mul_b = MUL_B_W'(RATE_PER_MS);
        end
        else if (ctrl.step_move)
        begin
            mul_a = MUL_A_W'(mag);
            mul_b = MUL_B_W'(k_val);
        end
    end

    // Apply the rounded move and snap near the target or on a jump
    assign move_round = {1'b0, prod} + (P_W+1)'(RATE_HALF);
    assign move       = GW'(move_round >> RATE_FRAC);
    assign stepped    = up_reg ? (smoothed_reg + move) : (smoothed_reg - move);
    assign snap_diff  = (target_reg >= stepped) ? (target_reg - stepped)
                                                : (stepped - target_reg);
    always_comb
    begin
        if (jump_reg || (snap_diff < SNAP_DIST))
        begin
            gain_new = target_reg;
        end
        else
        begin
            gain_new = stepped;
        end
    end

    // Hold the word and the per-step results
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg    <= time_ms;
            active_reg <= window_active;
        end
        if (ctrl.step_target)
        begin
            dt_reg   <= dt_full[DT_W-1:0];
            jump_reg <= !valid_reg || (now_reg < last_reg) || (dt_full > GAP_LIMIT);
        end
        if (ctrl.step_rate)
        begin
            target_reg <= target_calc;
            up_reg     <= (target_calc >= smoothed_reg);
        end
    end

    // Update the block state at the finish step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= '0;
            valid_reg    <= 1'b0;
            last_reg     <= '0;
        end
        else if (ctrl.step_finish)
        begin
            smoothed_reg <= gain_new;
            valid_reg    <= 1'b1;
            last_reg     <= now_reg;
        end
    end

    // Present the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.step_finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step_finish)
        begin
            gain_out_reg <= gain_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign gain      = gain_out_reg;

endmodule
